@@ sv/assert_macros.svh @@
// Assertion macros for the hillshade RTL, included by the core top level.
// No dependencies; define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is asserted
`define HMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: check failed");

// Clocked check that also holds during reset
`define HMS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`else

`define HMS_ASSERT(lbl, clk, rstn, prop)
`define HMS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ sv/hms_pkg.sv @@
// Shared constants, types and helpers for the height map hillshade core.
// No dependencies; imported by every module of the block.
`default_nettype none

package hms_pkg;

  // Parameter defaults
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;
  localparam int unsigned FracBitsDef  = 8;

  // Fixed field widths
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned ShadeBits   = 19;
  localparam int unsigned PosBits     = 11;
  localparam int unsigned CfgBits     = 12;
  localparam int unsigned DimBits     = 14;
  localparam int unsigned OutDataBits = 48;
  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Register map, decoded on paddr[2]
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;
  localparam logic [CfgBits-1:0] ImageWidthReset  = 12'd640;
  localparam logic [CfgBits-1:0] ImageHeightReset = 12'd480;

  // Result slots an input may cause, in issue order
  localparam int unsigned ResUpper  = 0;  // pixel one row up
  localparam int unsigned ResLower  = 1;  // left neighbor on the last row
  localparam int unsigned ResCorner = 2;  // final pixel of the frame
  localparam int unsigned ResSlots  = 3;

  typedef struct packed {
    logic last_col;
    logic has_left;   // column >= 1
    logic two_left;   // column >= 2
    logic has_up;     // row >= 1
    logic two_up;     // row >= 2
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [ResSlots-1:0] mask;
  } class_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  // Map a programmed dimension onto 1..maxv
  function automatic logic [DimBits-1:0] clamp_dim(logic [CfgBits-1:0] v,
                                                   logic [DimBits-1:0] maxv);
    logic [DimBits-1:0] ext;
    ext = DimBits'(v);
    if (ext == '0) begin
      return DimBits'(1);
    end
    if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

@@ sv/hms_regs.sv @@
// APB register file holding image width and height.
// Depends on hms_pkg for the register map and reset values.
`default_nettype none

module hms_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [hms_pkg::ApbAddrBits-1:0]  paddr,
  input  wire logic [hms_pkg::ApbDataBits-1:0]  pwdata,
  output logic      [hms_pkg::ApbDataBits-1:0]  prdata,
  output logic                                  pready,
  output logic      [hms_pkg::CfgBits-1:0]      img_w_o,
  output logic      [hms_pkg::CfgBits-1:0]      img_h_o
);
  import hms_pkg::*;

  logic [CfgBits-1:0] img_w_q;
  logic [CfgBits-1:0] img_h_q;
  logic               wr_en;

  assign wr_en = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ImageWidthReset;
      img_h_q <= ImageHeightReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegImageWidth:  img_w_q <= pwdata[CfgBits-1:0];
        RegImageHeight: img_h_q <= pwdata[CfgBits-1:0];
        default:        img_w_q <= img_w_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[2])
      RegImageWidth:  prdata = ApbDataBits'(img_w_q);
      RegImageHeight: prdata = ApbDataBits'(img_h_q);
      default:        prdata = '0;
    endcase
  end

  assign pready  = 1'b1;
  assign img_w_o = img_w_q;
  assign img_h_o = img_h_q;

endmodule

`default_nettype wire

@@ sv/hms_front.sv @@
// Front end: raster counters and per-sample classification.
// Depends on hms_pkg; feeds hms_queue with one word per accepted sample.
`default_nettype none

module hms_front #(
  parameter int unsigned MAX_WIDTH  = hms_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hms_pkg::MaxHeightDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [hms_pkg::CfgBits-1:0]            img_w_i,
  input  wire logic [hms_pkg::CfgBits-1:0]            img_h_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   q_full_i,
  output logic                                        q_push_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                q_col_o,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                q_nxt_o,
  output hms_pkg::class_t                             q_class_o
);
  import hms_pkg::*;

  localparam int unsigned ColBits = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [ColBits-1:0] col_q, col_d, col_nxt;
  logic [RowBits-1:0] row_q, row_d;
  logic [DimBits-1:0] dim_w, dim_h;
  logic               last_col, last_row, accept;

  assign dim_w = clamp_dim(img_w_i, DimBits'(MAX_WIDTH));
  assign dim_h = clamp_dim(img_h_i, DimBits'(MAX_HEIGHT));

  // Position of the incoming sample within the frame
  assign last_col = (DimBits'(col_q) + DimBits'(1)) >= dim_w;
  assign last_row = (DimBits'(row_q) + DimBits'(1)) >= dim_h;
  assign col_nxt  = last_col ? '0 : col_q + ColBits'(1);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Advance counters on each accepted word
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = col_nxt;
      if (last_col) begin
        row_d = last_row ? '0 : row_q + RowBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Classify: which results this sample releases and which neighbors exist
  always_comb begin
    q_class_o.flags.last_col = last_col;
    q_class_o.flags.has_left = col_q != '0;
    q_class_o.flags.two_left = DimBits'(col_q) >= DimBits'(2);
    q_class_o.flags.has_up   = row_q != '0;
    q_class_o.flags.two_up   = DimBits'(row_q) >= DimBits'(2);
    q_class_o.mask            = '0;
    q_class_o.mask[ResUpper]  = row_q != '0;
    q_class_o.mask[ResLower]  = last_row && (col_q != '0);
    q_class_o.mask[ResCorner] = last_row && last_col;
  end

  assign q_col_o = col_q;
  assign q_row_o = row_q;
  assign q_nxt_o = col_nxt;

endmodule

`default_nettype wire

@@ sv/hms_queue.sv @@
// Short register FIFO that decouples the front end from the back end.
// Depends on hms_pkg for the default depth.
`default_nettype none

module hms_queue #(
  parameter int unsigned DataBits = 32,
  parameter int unsigned Depth    = hms_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [DataBits-1:0] push_data_i,
  output logic                     full_o,
  output logic                     valid_o,
  output logic      [DataBits-1:0] data_o,
  input  wire logic                pop_i
);
  import hms_pkg::*;

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [DataBits-1:0] slot_q [Depth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  cnt_q;

  assign full_o  = cnt_q == CntBits'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/hms_back.sv @@
// Back end: line memory, neighbor window, shade arithmetic, result register.
// Depends on hms_pkg; pops words from hms_queue.
`default_nettype none

module hms_back #(
  parameter int unsigned MAX_WIDTH  = hms_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hms_pkg::MaxHeightDef,
  parameter int unsigned FRAC_BITS  = hms_pkg::FracBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   q_valid_i,
  input  wire logic [hms_pkg::SampleBits-1:0]         q_sample_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]           q_col_i,
  input  wire logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]           q_nxt_i,
  input  hms_pkg::class_t                             q_class_i,
  output hms_pkg::back_stat_t                         stat_o,
  output logic                                        m_valid_o,
  input  wire logic                                   m_ready_i,
  output logic [hms_pkg::OutDataBits-1:0]             m_data_o,
  output logic                                        m_last_o,
  output logic                                        m_user_o
);
  import hms_pkg::*;

  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WideBits = ShadeBits + 1;
  localparam int unsigned EntBits  = 2 * SampleBits;
  localparam logic signed [WideBits-1:0] One = WideBits'(1) << FRAC_BITS;

  // Line memory: upper half the row above, lower half two rows above
  logic [EntBits-1:0]    line_mem [MAX_WIDTH];
  logic [EntBits-1:0]    rd_q, wr_entry;

  // Item under work and its left-hand history
  logic [ResSlots-1:0]   mask_q;
  flags_t                flags_q;
  logic [SampleBits-1:0] cur_q, above_q, two_q;
  logic [SampleBits-1:0] rec0_q, rec1_q, prev_above_q;
  logic [ColBits-1:0]    col_q;
  logic [RowBits-1:0]    row_q;

  // Result register
  logic                  out_valid_q;
  logic [ShadeBits-1:0]  out_shade_q;
  logic [PosBits-1:0]    out_col_q, out_row_q;
  logic                  out_last_q, out_done_q;

  logic [ResSlots-1:0]   sel_oh, mask_rest;
  logic                  out_free, emit, pop;
  logic [SampleBits-1:0] op_l, op_r, op_u, op_d, self_px;
  logic [ColBits-1:0]    res_col;
  logic [RowBits-1:0]    res_row;
  logic                  res_done;
  logic signed [WideBits-1:0] sum;

  // Pick the next pending result, lowest slot first
  assign sel_oh    = mask_q & (~mask_q + ResSlots'(1));
  assign mask_rest = mask_q & ~sel_oh;
  assign out_free  = !out_valid_q || m_ready_i;
  assign emit      = (mask_q != '0) && out_free;
  assign pop       = q_valid_i && ((mask_q == '0) || (emit && (mask_rest == '0)));

  assign wr_entry  = {q_sample_i, rd_q[EntBits-1:SampleBits]};

  // Gather the neighbors of the selected pixel
  always_comb begin
    self_px  = above_q;
    op_l     = above_q;
    op_r     = above_q;
    op_u     = above_q;
    op_d     = cur_q;
    res_col  = col_q;
    res_row  = row_q - RowBits'(1);
    res_done = 1'b0;
    if (sel_oh[ResUpper]) begin
      self_px = above_q;
      op_r    = flags_q.last_col ? self_px : rd_q[EntBits-1:SampleBits];
      op_l    = flags_q.has_left ? prev_above_q : self_px;
      op_u    = flags_q.two_up ? two_q : self_px;
      op_d    = cur_q;
    end else if (sel_oh[ResLower]) begin
      self_px = rec0_q;
      op_l    = flags_q.two_left ? rec1_q : self_px;
      op_u    = flags_q.has_up ? prev_above_q : self_px;
      op_r    = cur_q;
      op_d    = self_px;
      res_col = col_q - ColBits'(1);
      res_row = row_q;
    end else begin
      op_l     = flags_q.has_left ? rec0_q : cur_q;
      op_u     = flags_q.has_up ? above_q : cur_q;
      op_r     = cur_q;
      op_d     = cur_q;
      res_row  = row_q;
      res_done = 1'b1;
    end
  end

  // Central differences plus one
  assign sum = (WideBits'($signed(op_r)) - WideBits'($signed(op_l)))
             + (WideBits'($signed(op_d)) - WideBits'($signed(op_u))) + One;

  // Control: pending slots and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mask_q <= q_class_i.mask;
      end else if (emit) begin
        mask_q <= mask_rest;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: memory access, window shift and result capture
  always_ff @(posedge clk_i) begin
    if (pop) begin
      line_mem[q_col_i] <= wr_entry;
      rd_q         <= (q_nxt_i == q_col_i) ? wr_entry : line_mem[q_nxt_i];
      rec1_q       <= rec0_q;
      rec0_q       <= cur_q;
      prev_above_q <= above_q;
      cur_q        <= q_sample_i;
      above_q      <= rd_q[EntBits-1:SampleBits];
      two_q        <= rd_q[SampleBits-1:0];
      flags_q      <= q_class_i.flags;
      col_q        <= q_col_i;
      row_q        <= q_row_i;
    end
    if (emit) begin
      out_shade_q <= sum[ShadeBits-1:0];
      out_col_q   <= PosBits'(res_col);
      out_row_q   <= PosBits'(res_row);
      out_last_q  <= mask_rest == '0;
      out_done_q  <= res_done;
    end
  end

  assign stat_o.pop  = pop;
  assign stat_o.busy = mask_q != '0;
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = OutDataBits'({out_row_q, out_col_q, out_shade_q});
  assign m_last_o    = out_last_q;
  assign m_user_o    = out_done_q;

endmodule

`default_nettype wire

@@ sv/height_map_hillshade_core.sv @@
// Height map hillshade core. Takes one signed height sample per clock in raster
// order while the input queue has room and returns shade = horizontal + vertical
// central difference + one for each pixel, clamping neighbors at the image edges.
// A sample enters every cycle unless the queue is full; a sample that releases
// several results (each last-row sample past the first column and the last
// sample of the frame) holds the output until all of them have left, while a
// four-word queue keeps taking input. Throughput is set by the single line
// memory, which does one read and one write per cycle while words are popped,
// and by the one result register. The line memory needs no clearing after
// reset. Registers: image_width at 0x0, image_height at 0x4.
`default_nettype none

`include "assert_macros.svh"

module height_map_hillshade_core #(
  parameter int unsigned MAX_WIDTH  = hms_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hms_pkg::MaxHeightDef,
  parameter int unsigned FRAC_BITS  = hms_pkg::FracBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Sample stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [hms_pkg::SampleBits-1:0]     s_axis_tdata,  // [15:0] height_sample
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [18:0] shade, [29:19] out_column, [40:30] out_row, [47:41] zero
  output logic      [hms_pkg::OutDataBits-1:0]    m_axis_tdata,
  output logic                                    m_axis_tlast,  // run_last
  output logic                                    m_axis_tuser,  // [0] frame_done
  // Register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [hms_pkg::ApbAddrBits-1:0]    paddr,
  input  wire logic [hms_pkg::ApbDataBits-1:0]    pwdata,
  output logic      [hms_pkg::ApbDataBits-1:0]    prdata,
  output logic                                    pready
);
  import hms_pkg::*;

  localparam int unsigned ColBits   = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ClassBits = $bits(class_t);
  localparam int unsigned WordBits  = SampleBits + 2 * ColBits + RowBits + ClassBits;

  logic [CfgBits-1:0]  img_w, img_h;
  logic                q_full, q_push, q_valid;
  logic [ColBits-1:0]  f_col, f_nxt, b_col, b_nxt;
  logic [RowBits-1:0]  f_row, b_row;
  class_t              f_class, b_class;
  logic [SampleBits-1:0] b_sample;
  logic [WordBits-1:0] push_word, head_word;
  back_stat_t          back_stat;
  logic                out_room;

  hms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .img_w_o (img_w),
    .img_h_o (img_h)
  );

  hms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .img_w_i    (img_w),
    .img_h_i    (img_h),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_col_o    (f_col),
    .q_row_o    (f_row),
    .q_nxt_o    (f_nxt),
    .q_class_o  (f_class)
  );

  // Pack one classified sample per queue word
  assign push_word = {s_axis_tdata, f_col, f_row, f_nxt, f_class};

  hms_queue #(
    .DataBits (WordBits),
    .Depth    (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_word),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (head_word),
    .pop_i       (back_stat.pop)
  );

  assign {b_sample, b_col, b_row, b_nxt, b_class} = head_word;

  hms_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_sample_i (b_sample),
    .q_col_i    (b_col),
    .q_row_i    (b_row),
    .q_nxt_i    (b_nxt),
    .q_class_i  (b_class),
    .stat_o     (back_stat),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_user_o   (m_axis_tuser)
  );

  // Result register can take a word this cycle
  assign out_room = !m_axis_tvalid || m_axis_tready;

  // The frame's final result always closes its run
  `HMS_ASSERT(a_done_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
  // The back end only pops a word the queue holds
  `HMS_ASSERT(a_pop_has_word, clk_i, rst_ni, back_stat.pop |-> q_valid)
  // Input ready returns only after the back end frees a slot
  `HMS_ASSERT(a_ready_after_pop, clk_i, rst_ni, $rose(s_axis_tready) |-> $past(back_stat.pop))
  // A busy back end retires its item only when the result register has room
  `HMS_ASSERT(a_pop_room, clk_i, rst_ni, back_stat.pop && back_stat.busy |-> out_room)
  // No result is offered while reset is held
  `HMS_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for height_map_hillshade_core: streams height frames,
// predicts every shade word in place and compares it field by field.
// Depends on hms_pkg and the core RTL only.
`default_nettype none

module tb_top;

  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 8;    // pipeline latency plus margin
  localparam int HoldOffCycles = 300;
  localparam int DirRows       = 24;
  localparam int ShadeOne      = 1 << hms_pkg::FracBitsDef;

  // Register byte addresses
  localparam logic [hms_pkg::ApbAddrBits-1:0] AddrImageWidth  = 3'h0;
  localparam logic [hms_pkg::ApbAddrBits-1:0] AddrImageHeight = 3'h4;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic [18:0] shade;
    logic [10:0] col;
    logic [10:0] row;
    logic        run_last;
    logic        frame_done;
  } shade_res_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] sample;
    logic        known;
    logic [18:0] shade;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] height_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [18:0] shade, [29:19] out_column, [40:30] out_row
  logic        m_axis_tlast;   // run_last
  logic        m_axis_tuser;   // [0] frame_done
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [hms_pkg::ApbAddrBits-1:0] paddr;
  logic [hms_pkg::ApbDataBits-1:0] pwdata;
  logic [hms_pkg::ApbDataBits-1:0] prdata;
  logic        pready;

  // Shade predictor state
  logic [11:0]        cfg_width  = hms_pkg::ImageWidthReset;
  logic [11:0]        cfg_height = hms_pkg::ImageHeightReset;
  logic signed [15:0] line_above     [hms_pkg::MaxWidthDef];
  logic signed [15:0] line_two_above [hms_pkg::MaxWidthDef];
  logic signed [15:0] recent0 = '0;
  logic signed [15:0] recent1 = '0;
  int                 col_cnt = 0;
  int                 row_cnt = 0;

  shade_res_t expected_shades[$];
  dir_row_t   dir_rows[DirRows];
  int         errors       = 0;
  int         cycle_count  = 0;
  int         tx_idle_pct  = 0;
  int         rx_stall_pct = 0;
  int         sample_count = 0;
  logic       hold_toggle;

  height_map_hillshade_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Map a programmed dimension onto 1..maxv
  function automatic int eff_dim(logic [11:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic shade_res_t make_shade(int left, int right, int up, int down,
                                            int col, int row, bit done);
    shade_res_t r;
    int s;
    s            = (right - left) + (down - up) + ShadeOne;
    r.shade      = s[18:0];
    r.col        = col[10:0];
    r.row        = row[10:0];
    r.run_last   = 1'b0;
    r.frame_done = done;
    return r;
  endfunction

  // Work out the shades one sample releases, then advance the line stores
  function automatic void predict_shades(input logic [15:0] sample,
                                         output shade_res_t res [3], output int n);
    int w, h, c, r, cur, slf, lft, rgt, up;
    bit last_col, last_row;
    w        = eff_dim(cfg_width, hms_pkg::MaxWidthDef);
    h        = eff_dim(cfg_height, hms_pkg::MaxHeightDef);
    c        = col_cnt;
    r        = row_cnt;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    cur      = $signed(sample);
    n        = 0;
    // pixel one row up: its lower neighbor just arrived
    if (r >= 1) begin
      slf = line_above[c];
      rgt = (c + 1 < w) ? line_above[c + 1] : slf;
      lft = (c >= 1) ? line_two_above[c - 1] : slf;
      up  = (r >= 2) ? line_two_above[c] : slf;
      res[n] = make_shade(lft, rgt, up, cur, c, r - 1, 1'b0);
      n++;
    end
    // last row: left neighbor now has its right side
    if (last_row && c >= 1) begin
      slf = recent0;
      lft = (c >= 2) ? recent1 : slf;
      up  = (r >= 1) ? line_two_above[c - 1] : slf;
      res[n] = make_shade(lft, cur, up, slf, c - 1, r, 1'b0);
      n++;
    end
    // final pixel of the frame
    if (last_row && last_col) begin
      lft = (c >= 1) ? recent0 : cur;
      up  = (r >= 1) ? line_above[c] : cur;
      res[n] = make_shade(lft, cur, up, cur, c, r, 1'b1);
      n++;
    end
    if (n > 0) res[n - 1].run_last = 1'b1;

    line_two_above[c] = line_above[c];
    line_above[c]     = sample;
    recent1           = recent0;
    recent0           = sample;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // Mostly random heights, with the extremes and small values mixed in
  function automatic logic [15:0] next_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // One register access: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [hms_pkg::ApbAddrBits-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [hms_pkg::ApbAddrBits-1:0] addr,
                           input logic [11:0] want, input string name);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    if (rd != 32'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, rd);
      errors++;
    end
  endtask

  // Drain the block, then program a new geometry
  task automatic configure(input logic [11:0] w, input logic [11:0] h);
    logic [31:0] rd;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_shades.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    apb_access(1'b1, AddrImageWidth, 32'(w), rd);
    cfg_width = w;
    apb_access(1'b1, AddrImageHeight, 32'(h), rd);
    cfg_height = h;
    check_reg(AddrImageWidth, w, "image_width");
    check_reg(AddrImageHeight, h, "image_height");
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IdleSender:   begin tx_idle_pct = 46; rx_stall_pct <= 0;  end
      IdleReceiver: begin tx_idle_pct = 0;  rx_stall_pct <= 46; end
      IdleBoth:     begin tx_idle_pct = 26; rx_stall_pct <= 26; end
      default:      begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
    endcase
  endtask

  // Offer one height word, then queue the shades it releases
  task automatic send_sample(input logic [15:0] sample, input bit known,
                             input logic [18:0] known_shade);
    shade_res_t res [3];
    shade_res_t typed;
    int n;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_shades(sample, res, n);
    if (known) begin
      // one-pixel image: every sample is its own final pixel
      typed = '{shade: known_shade, col: '0, row: '0, run_last: 1'b1, frame_done: 1'b1};
      expected_shades.push_back(typed);
    end else begin
      for (int k = 0; k < n; k++) expected_shades.push_back(res[k]);
    end
  endtask

  // Whole frames only, so no line store entry is read before it is written
  task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input int frames,
                           input idle_mode_e mode, input bit pressure);
    int pixels;
    configure(w, h);
    set_idle(mode);
    pixels = eff_dim(w, hms_pkg::MaxWidthDef) * eff_dim(h, hms_pkg::MaxHeightDef);
    for (int f = 0; f < frames; f++) begin
      for (int p = 0; p < pixels; p++) begin
        if (pressure && f == 0 && p == 8) hold_toggle <= ~hold_toggle;
        if (pressure && f == 0 && p == 20) begin
          // pause until every pending shade has come out
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (expected_shades.size() != 0);
        end
        send_sample(next_sample(), 1'b0, '0);
        sample_count++;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int   hold_left;
    logic hold_seen;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_seen     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each accepted shade word with the oldest expectation
  always @(posedge clk_i) begin : shade_check
    shade_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_shades.size() == 0) begin
        $error("unexpected shade word: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_shades.pop_front();
        if (m_axis_tdata[18:0] != want.shade) begin
          $error("shade: expected %0d, got %0d", $signed(want.shade),
                 $signed(m_axis_tdata[18:0]));
          errors++;
        end
        if (m_axis_tdata[29:19] != want.col) begin
          $error("out_column: expected %0d, got %0d", want.col, m_axis_tdata[29:19]);
          errors++;
        end
        if (m_axis_tdata[40:30] != want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[40:30]);
          errors++;
        end
        if (m_axis_tlast != want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser != want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [11:0] w;
    logic [11:0] h;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_toggle   = 1'b0;
    for (int k = 0; k < hms_pkg::MaxWidthDef; k++) begin
      line_above[k]     = '0;
      line_two_above[k] = '0;
    end

    // Directed frames: 1x1 (zero and one), 2x2, one row, one column, 3x3
    dir_rows = '{
      '{12'd0, 12'd0, 16'h8000, 1'b1, 19'd256},
      '{12'd0, 12'd0, 16'h7fff, 1'b1, 19'd256},
      '{12'd0, 12'd0, 16'h0000, 1'b1, 19'd256},
      '{12'd1, 12'd1, 16'hffff, 1'b1, 19'd256},
      '{12'd1, 12'd1, 16'h0001, 1'b1, 19'd256},
      '{12'd2, 12'd2, 16'h8000, 1'b0, 19'd0},
      '{12'd2, 12'd2, 16'h7fff, 1'b0, 19'd0},
      '{12'd2, 12'd2, 16'h7fff, 1'b0, 19'd0},
      '{12'd2, 12'd2, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd1, 16'h7fff, 1'b0, 19'd0},
      '{12'd3, 12'd1, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd1, 16'h7fff, 1'b0, 19'd0},
      '{12'd1, 12'd3, 16'h8000, 1'b0, 19'd0},
      '{12'd1, 12'd3, 16'h7fff, 1'b0, 19'd0},
      '{12'd1, 12'd3, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h7fff, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h7fff, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h7fff, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h8000, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h0100, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'hff00, 1'b0, 19'd0},
      '{12'd3, 12'd3, 16'h1234, 1'b0, 19'd0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers come up at their reset geometry
    check_reg(AddrImageWidth, hms_pkg::ImageWidthReset, "image_width");
    check_reg(AddrImageHeight, hms_pkg::ImageHeightReset, "image_height");

    set_idle(IdleNone);
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].width != cfg_width || dir_rows[i].height != cfg_height)
        configure(dir_rows[i].width, dir_rows[i].height);
      send_sample(dir_rows[i].sample, dir_rows[i].known, dir_rows[i].shade);
    end

    // Back-pressure frame, then small random frames under every idle mode
    run_phase(12'd6, 12'd5, 1, IdleNone, 1'b1);
    phase = 0;
    while (sample_count < 96 || phase < 4) begin
      w = 12'($urandom_range(8, 1));
      h = 12'($urandom_range(5, 1));
      if ($urandom_range(5) == 0) w = '0;
      if ($urandom_range(5) == 0) h = '0;
      run_phase(w, h, $urandom_range(2, 1), idle_mode_e'(phase % 4), 1'b0);
      phase++;
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_shades.size() != 0);
    repeat (4 * SettleCycles) @(posedge clk_i);

    if (errors == 0 && expected_shades.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ height_map_hillshade_core.f @@
+incdir+sv
sv/hms_pkg.sv
sv/hms_regs.sv
sv/hms_front.sv
sv/hms_queue.sv
sv/hms_back.sv
sv/height_map_hillshade_core.sv
test/tb_top.sv
